>>> design/sorted_timeout_queue_core_macros.svh
// assertion helpers for the timeout queue
`ifndef SORTED_TIMEOUT_QUEUE_CORE_MACROS_SVH
`define SORTED_TIMEOUT_QUEUE_CORE_MACROS_SVH
`define STQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: lbl");
`define STQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("%m: lbl");
`endif

>>> design/stq_pkg.sv
`default_nettype none
package stq_pkg;
  localparam int unsigned KindW = 3;
  localparam int unsigned IdW = 4;
  localparam int unsigned MsW = 31;
  localparam int unsigned MillisW = 32;
  localparam int unsigned MaxBurst = 16;

  typedef enum logic [KindW-1:0] {
    KIND_TICK   = 3'd0,
    KIND_SET    = 3'd1,
    KIND_CANCEL = 3'd2,
    KIND_REM    = 3'd3,
    KIND_NEXT   = 3'd4
  } kind_e;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_RDHEAD = 8'b0000_0010,
    ST_EXP    = 8'b0000_0100,
    ST_SCAN   = 8'b0000_1000,
    ST_SHIFT  = 8'b0001_0000,
    ST_INS    = 8'b0010_0000,
    ST_OUT    = 8'b0100_0000,
    ST_NEXT   = 8'b1000_0000
  } state_e;
endpackage
`default_nettype wire

>>> design/sorted_timeout_queue_core.sv
// Timeout queue keeping up to NUM_TIMERS timers in deadline order, ties in arrival
// order. Slot numbers in list order sit in an order memory and deadlines in a
// deadline memory, both with a registered synchronous read, and every walk of the
// list goes through the single order port. A remaining or next query, or a cancel
// or set of a slot that is not pending, loads its beat into the output register
// once its reads are done (a set of such a slot first searches its place in the
// list). A cancel of a pending timer walks the list to it and closes the gap; a
// set of a pending timer unlinks and re-inserts it. A tick, for each timer it
// expires, reads the head, checks its deadline and closes the gap, and then checks
// the count, the burst size and the next head to see whether the burst is over;
// each expiry beat is held back until its last flag is known, so it leaves when
// the following head has been checked. At most 16 expiries per tick; the rest stay
// due for the next tick. The result sits in one output register and no new input
// beat is taken until it has drained.
`default_nettype none
module sorted_timeout_queue_core #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [stq_pkg::KindW-1:0] kind_i,
  input  wire logic [stq_pkg::IdW-1:0]   timer_id_i,
  input  wire logic [stq_pkg::MsW-1:0]   msecs_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [stq_pkg::KindW-1:0]   result_kind_o,
  output logic                        status_o,
  output logic [stq_pkg::IdW-1:0]     expired_id_o,
  output logic signed [stq_pkg::MillisW-1:0] millis_o,
  output logic                        last_o
);
  import stq_pkg::*;
  localparam int unsigned SW = $clog2(NUM_TIMERS);
  localparam int unsigned CW = $clog2(NUM_TIMERS + 2);
  localparam int unsigned BW = $clog2(MaxBurst + 1);
  localparam int unsigned WW = TIME_BITS + MillisW;
  localparam logic signed [WW-1:0] MsMax = WW'({1'b0, {(MillisW-1){1'b1}}});

  logic [TIME_BITS-1:0] dl_mem [NUM_TIMERS];
  logic [SW-1:0]        ord_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] pend_q, pend_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [CW-1:0] cnt_q, cnt_d;
  state_e st_q, st_d;
  logic [KindW-1:0] kind_q, kind_d;
  logic [IdW-1:0] id_q, id_d;
  logic [TIME_BITS-1:0] newdl_q, newdl_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [BW-1:0] nexp_q, nexp_d;
  logic phase_q, phase_d;
  logic [SW-1:0] shv_q, shv_d;
  logic [SW-1:0] hold_q, hold_d;
  logic hit_q, hit_d;

  logic ov_q, ov_d;
  logic [KindW-1:0] rk_q, rk_d;
  logic rs_q, rs_d, rl_q, rl_d;
  logic [IdW-1:0] ri_q, ri_d;
  logic [MillisW-1:0] rm_q, rm_d;

  // memory ports
  logic dl_we; logic [SW-1:0] dl_wa, dl_ra; logic [TIME_BITS-1:0] dl_wd, dl_rd;
  logic ord_we; logic [SW-1:0] ord_wa, ord_ra, ord_wd, ord_rd;

  always_ff @(posedge clk_i) begin
    if (dl_we) dl_mem[dl_wa] <= dl_wd;
    dl_rd <= dl_mem[dl_ra];
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_rd <= ord_mem[ord_ra];
  end

  function automatic logic later(input logic [TIME_BITS-1:0] a, input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_BITS-1];
  endfunction

  function automatic logic [MillisW-1:0] sat(input logic [TIME_BITS-1:0] d);
    logic signed [WW-1:0] sx;
    sx = WW'($signed(d));
    if (sx > MsMax) return {1'b0, {(MillisW-1){1'b1}}};
    if (sx < ~MsMax) return {1'b1, {(MillisW-1){1'b0}}};
    return sx[MillisW-1:0];
  endfunction

  wire id_ok = ({{(32-IdW){1'b0}}, id_q} < NUM_TIMERS);
  wire [SW-1:0] ids = SW'(id_q);
  wire in_ok = ({{(32-IdW){1'b0}}, timer_id_i} < NUM_TIMERS);
  wire [SW-1:0] in_slot = SW'(timer_id_i);
  wire out_free = !ov_q || out_ready_i;
  assign in_ready_o = (st_q == ST_IDLE) && !ov_q;

  always_comb begin
    st_d = st_q; kind_d = kind_q; id_d = id_q; newdl_d = newdl_q;
    idx_d = idx_q; pos_d = pos_q; nexp_d = nexp_q; phase_d = phase_q; shv_d = shv_q;
    hold_d = hold_q; hit_d = hit_q;
    pend_d = pend_q; now_d = now_q; cnt_d = cnt_q;
    ov_d = ov_q && !out_ready_i; rk_d = rk_q; rs_d = rs_q; rl_d = rl_q; ri_d = ri_q; rm_d = rm_q;
    dl_we = 1'b0; dl_wa = ids; dl_wd = newdl_q; dl_ra = ids;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          kind_d = kind_i; id_d = timer_id_i;
          newdl_d = now_q + TIME_BITS'(msecs_i);
          idx_d = '0; nexp_d = '0; phase_d = 1'b0;
          unique case (kind_i) inside
            KIND_TICK: begin now_d = now_q + 1'b1; st_d = ST_RDHEAD; end
            KIND_SET, KIND_CANCEL, KIND_REM: begin
              dl_ra = in_slot; st_d = ST_OUT;
              hit_d = in_ok && pend_q[in_slot];
              if (hit_d && kind_i != KIND_REM)
                st_d = ST_SCAN;
              else if (kind_i == KIND_SET && in_ok)
                st_d = ST_INS;
            end
            KIND_NEXT: begin ord_ra = '0; st_d = ST_NEXT; end
            default: st_d = ST_IDLE;
          endcase
          pos_d = cnt_q;
        end
      end
      // tick: read head slot, then its deadline; the held expiry goes out once
      // it is known whether another one follows
      ST_RDHEAD: begin
        if (cnt_q == '0 || nexp_q == BW'(MaxBurst)) begin
          if (nexp_q == '0) st_d = ST_IDLE;
          else if (out_free) begin
            ov_d = 1'b1; rk_d = KIND_TICK; rs_d = 1'b0; ri_d = IdW'(hold_q);
            rm_d = '0; rl_d = 1'b1; st_d = ST_IDLE;
          end
        end else if (!phase_q) begin
          ord_ra = '0; phase_d = 1'b1;
        end else begin
          dl_ra = ord_rd; shv_d = ord_rd; phase_d = 1'b0; st_d = ST_EXP;
        end
      end
      ST_EXP: begin
        // keep the head deadline on the read port while waiting for the output
        dl_ra = shv_q;
        if (later(dl_rd, now_q)) begin
          if (nexp_q == '0) st_d = ST_IDLE;
          else if (out_free) begin
            ov_d = 1'b1; rk_d = KIND_TICK; rs_d = 1'b0; ri_d = IdW'(hold_q);
            rm_d = '0; rl_d = 1'b1; st_d = ST_IDLE;
          end
        end else if (nexp_q == '0 || out_free) begin
          if (nexp_q != '0) begin
            ov_d = 1'b1; rk_d = KIND_TICK; rs_d = 1'b0; ri_d = IdW'(hold_q);
            rm_d = '0; rl_d = 1'b0;
          end
          hold_d = shv_q;
          pend_d[shv_q] = 1'b0;
          pos_d = '0; idx_d = CW'(1); st_d = ST_SHIFT;
          nexp_d = nexp_q + 1'b1;
        end
      end
      // scan for id (set or cancel) to unlink; idx walks the list
      ST_SCAN: begin
        if (!phase_q) begin
          ord_ra = idx_q[SW-1:0]; phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (ord_rd == ids) begin
            pos_d = idx_q; idx_d = idx_q + 1'b1; st_d = ST_SHIFT;
            pend_d[ids] = 1'b0;
          end else idx_d = idx_q + 1'b1;
        end
      end
      // close gap: order[pos] = order[pos+1] ... then drop count
      ST_SHIFT: begin
        if (idx_q >= cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          idx_d = '0; phase_d = 1'b0;
          if (kind_q == KIND_TICK) st_d = ST_RDHEAD;
          else if (kind_q == KIND_SET) st_d = ST_INS;
          else st_d = ST_OUT;
        end else if (!phase_q) begin
          ord_ra = idx_q[SW-1:0]; phase_d = 1'b1;
        end else begin
          ord_we = 1'b1; ord_wa = pos_q[SW-1:0]; ord_wd = ord_rd;
          pos_d = pos_q + 1'b1; idx_d = idx_q + 1'b1; phase_d = 1'b0;
        end
      end
      // insert: find first entry later than new deadline, then shift tail up
      ST_INS: begin
        if (idx_q == '0 && !phase_q) begin
          dl_we = 1'b1; pos_d = cnt_q;
        end
        if (cnt_q == CW'(NUM_TIMERS)) st_d = ST_OUT;
        else if (idx_q < cnt_q && pos_q == cnt_q) begin
          if (!phase_q) begin
            ord_ra = idx_q[SW-1:0]; phase_d = 1'b1;
          end else begin
            dl_ra = ord_rd; phase_d = 1'b0;
            idx_d = idx_q; pos_d = CW'(NUM_TIMERS + 1); shv_d = ord_rd;
          end
        end else if (pos_q == CW'(NUM_TIMERS + 1)) begin
          if (later(dl_rd, newdl_q)) begin
            pos_d = idx_q; idx_d = cnt_q;
          end else begin
            pos_d = cnt_q; idx_d = idx_q + 1'b1;
          end
        end else if (idx_q > pos_q) begin
          if (!phase_q) begin
            ord_ra = SW'(idx_q - 1'b1); phase_d = 1'b1;
          end else begin
            ord_we = 1'b1; ord_wa = idx_q[SW-1:0]; ord_wd = ord_rd;
            idx_d = idx_q - 1'b1; phase_d = 1'b0;
          end
        end else begin
          ord_we = 1'b1; ord_wa = pos_q[SW-1:0]; ord_wd = ids;
          cnt_d = cnt_q + 1'b1; pend_d[ids] = 1'b1;
          dl_ra = ids; st_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!phase_q) begin
          dl_ra = ids; phase_d = 1'b1;
        end else if (!ov_q) begin
          phase_d = 1'b0;
          ov_d = 1'b1; rk_d = kind_q; ri_d = id_q; rl_d = 1'b1; rm_d = '0;
          rs_d = !id_ok;
          if (kind_q == KIND_CANCEL) rs_d = !hit_q;
          if (kind_q == KIND_REM) begin
            rs_d = !(id_ok && pend_q[ids]);
            if (id_ok && pend_q[ids]) rm_d = sat(dl_rd - now_q);
          end
          st_d = ST_IDLE;
        end
      end
      ST_NEXT: begin
        if (!phase_q) begin
          dl_ra = ord_rd; shv_d = ord_rd; phase_d = 1'b1;
        end else if (!ov_q) begin
          phase_d = 1'b0; ov_d = 1'b1; rk_d = KIND_NEXT; rl_d = 1'b1;
          if (cnt_q == '0) begin
            rs_d = 1'b1; ri_d = '0; rm_d = '0;
          end else begin
            rs_d = 1'b0; ri_d = IdW'(shv_q);
            rm_d = sat(dl_rd - now_q);
            if (rm_d[MillisW-1]) rm_d = '0;
          end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; pend_q <= '0; now_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
      phase_q <= 1'b0; nexp_q <= '0; idx_q <= '0; pos_q <= '0;
    end else begin
      st_q <= st_d; pend_q <= pend_d; now_q <= now_d; cnt_q <= cnt_d; ov_q <= ov_d;
      phase_q <= phase_d; nexp_q <= nexp_d; idx_q <= idx_d; pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; id_q <= id_d; newdl_q <= newdl_d; shv_q <= shv_d;
    hold_q <= hold_d; hit_q <= hit_d;
    rk_q <= rk_d; rs_q <= rs_d; ri_q <= ri_d; rm_q <= rm_d; rl_q <= rl_d;
  end

  assign out_valid_o = ov_q;
  assign result_kind_o = rk_q;
  assign status_o = rs_q;
  assign expired_id_o = ri_q;
  assign millis_o = rm_q;
  assign last_o = rl_q;
endmodule
`default_nettype wire

>>> design/stq_checker.sv
`default_nettype none
`include "sorted_timeout_queue_core_macros.svh"
module stq_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic [2:0] result_kind_o,
  input wire logic status_o,
  input wire logic signed [31:0] millis_o
);
  import stq_pkg::*;
  `STQ_ASSERT(a_no_accept_while_out, clk_i, rst_ni, out_valid_o |-> !in_ready_o)
  `STQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(millis_o))
  `STQ_ASSERT(a_next_nonneg, clk_i, rst_ni, (out_valid_o && result_kind_o == KIND_NEXT) |-> !millis_o[31])
  `STQ_ASSERT(a_kind_range, clk_i, rst_ni, out_valid_o |-> (result_kind_o <= KIND_NEXT))
  `STQ_ASSERT(a_expiry_ok, clk_i, rst_ni, (out_valid_o && result_kind_o == KIND_TICK) |-> !status_o)
endmodule
bind sorted_timeout_queue_core stq_checker u_stq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .result_kind_o(result_kind_o),
  .status_o(status_o), .millis_o(millis_o)
);
`default_nettype wire

>>> test/sorted_timeout_queue_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module sorted_timeout_queue_core_tb;
  import stq_pkg::*;

  localparam int unsigned Slots = 16;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 120;

  typedef struct packed {
    logic [KindW-1:0]          kind;
    logic                      status;
    logic [IdW-1:0]            id;
    logic signed [MillisW-1:0] millis;
    logic                      last;
  } timer_result_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   id;
    logic [MsW-1:0]   msecs;
    logic             typed;
    timer_result_t    res;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [KindW-1:0] kind_i, result_kind_o;
  logic [IdW-1:0] timer_id_i, expired_id_o;
  logic [MsW-1:0] msecs_i;
  logic status_o, last_o;
  logic signed [MillisW-1:0] millis_o;

  sorted_timeout_queue_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .timer_id_i, .msecs_i,
    .out_valid_o, .out_ready_i, .result_kind_o, .status_o, .expired_id_o, .millis_o,
    .last_o
  );

  // predictor state
  logic [31:0] clock_ms;
  logic [31:0] due_at [Slots];
  logic        armed [Slots];
  logic [3:0]  slot_order [Slots];
  int unsigned armed_count;

  timer_result_t pending_results [$];
  int unsigned errors, sent_items, seen_results, sender_idle, receiver_idle;
  bit want_hold;
  stim_row_t dir_rows [24];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit due_later(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d != 0 && !d[31];
  endfunction

  function automatic void drop_timer(int unsigned id);
    int unsigned p;
    p = armed_count;
    for (int unsigned i = 0; i < armed_count; i++)
      if (slot_order[i] == id && p == armed_count) p = i;
    if (p < armed_count) begin
      for (int unsigned i = p; i + 1 < armed_count; i++) slot_order[i] = slot_order[i + 1];
      armed_count--;
    end
    armed[id] = 1'b0;
  endfunction

  function automatic void arm_timer(int unsigned id);
    int unsigned p;
    p = armed_count;
    if (armed_count >= Slots) return;
    for (int unsigned i = 0; i < armed_count; i++)
      if (p == armed_count && due_later(due_at[slot_order[i]], due_at[id])) p = i;
    for (int unsigned i = armed_count; i > p; i--) slot_order[i] = slot_order[i - 1];
    slot_order[p] = id[3:0];
    armed_count++;
    armed[id] = 1'b1;
  endfunction

  function automatic void predict_timers(logic [KindW-1:0] kind, logic [IdW-1:0] id,
                                         logic [MsW-1:0] ms);
    timer_result_t r;
    logic [31:0] d;
    int n;
    n = 0;
    r = '0;
    r.kind = kind;
    r.id = id;
    r.last = 1'b1;
    case (kind)
      KIND_TICK: begin
        clock_ms = clock_ms + 32'd1;
        while (armed_count > 0 && n < MaxBurst &&
               !due_later(due_at[slot_order[0]], clock_ms)) begin
          r.id = slot_order[0];
          r.last = 1'b0;
          drop_timer(32'(slot_order[0]));
          pending_results.push_back(r);
          n++;
        end
        if (n > 0) pending_results[pending_results.size() - 1].last = 1'b1;
      end
      KIND_SET: begin
        if (armed[id]) drop_timer(32'(id));
        due_at[id] = clock_ms + {1'b0, ms};
        arm_timer(32'(id));
        pending_results.push_back(r);
      end
      KIND_CANCEL: begin
        if (armed[id]) drop_timer(32'(id));
        else r.status = 1'b1;
        pending_results.push_back(r);
      end
      KIND_REM: begin
        if (armed[id]) r.millis = due_at[id] - clock_ms;
        else r.status = 1'b1;
        pending_results.push_back(r);
      end
      KIND_NEXT: begin
        if (armed_count == 0) begin
          r.status = 1'b1;
          r.id = '0;
        end else begin
          r.id = slot_order[0];
          d = due_at[slot_order[0]] - clock_ms;
          r.millis = d[31] ? '0 : d;
        end
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // one beat on the input channel, starting at a falling edge
  task automatic send_item(logic [KindW-1:0] kind, logic [IdW-1:0] id, logic [MsW-1:0] ms,
                           bit typed = 0, timer_result_t res = '0);
    int unsigned base;
    @(negedge clk_i);
    if ($urandom_range(99) < sender_idle) begin
      in_valid_i <= 1'b0;
      while ($urandom_range(99) < sender_idle) @(negedge clk_i);
      @(negedge clk_i);
    end
    kind_i <= kind;
    timer_id_i <= id;
    msecs_i <= ms;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    base = pending_results.size();
    predict_timers(kind, id, ms);
    if (typed) begin
      while (pending_results.size() > base) void'(pending_results.pop_back());
      pending_results.push_back(res);
    end
    sent_items++;
  endtask

  task automatic random_items(int unsigned count);
    int unsigned pick;
    logic [MsW-1:0] ms;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0: ms = MsW'($urandom);
        1: ms = {MsW{1'b1}};
        default: ms = MsW'($urandom_range(20));
      endcase
      if (pick < 5) begin
        // fill every slot with near deadlines so the ticks that follow expire all of them
        for (int unsigned i = 0; i < Slots; i++)
          send_item(KIND_SET, i[3:0], MsW'($urandom_range(2)));
        repeat (3) send_item(KIND_TICK, IdW'($urandom), MsW'($urandom));
      end else if (pick < 42) send_item(KIND_TICK, IdW'($urandom), MsW'($urandom));
      else if (pick < 67) send_item(KIND_SET, IdW'($urandom), ms);
      else if (pick < 77) send_item(KIND_CANCEL, IdW'($urandom), MsW'($urandom));
      else if (pick < 87) send_item(KIND_REM, IdW'($urandom), MsW'($urandom));
      else if (pick < 96) send_item(KIND_NEXT, IdW'($urandom), MsW'($urandom));
      else send_item(KindW'($urandom_range(7, 5)), IdW'($urandom), MsW'($urandom));
    end
  endtask

  // receiver: random stalls, plus a long hold when asked
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (want_hold) begin
        want_hold = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= receiver_idle);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      timer_result_t got, want;
      got = '{result_kind_o, status_o, expired_id_o, millis_o, last_o};
      seen_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: expected no beat, got kind=%0d id=%0d", $time, got.kind, got.id);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind) begin
          errors++;
          $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
        end
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        end
        if (got.id !== want.id) begin
          errors++;
          $display("%0t: id expected %0d got %0d", $time, want.id, got.id);
        end
        if (got.millis !== want.millis) begin
          errors++;
          $display("%0t: millis expected %0d got %0d", $time, want.millis, got.millis);
        end
        if (got.last !== want.last) begin
          errors++;
          $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("timeout at %0t", $time);
        $display("sorted_timeout_queue_core_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = '0;
    timer_id_i = '0;
    msecs_i = '0;
    want_hold = 1'b0;
    errors = 0;
    sent_items = 0;
    seen_results = 0;
    sender_idle = 16;
    receiver_idle = 85;
    clock_ms = '0;
    armed_count = 0;
    for (int i = 0; i < Slots; i++) begin
      armed[i] = 1'b0;
      due_at[i] = '0;
      slot_order[i] = '0;
    end
    dir_rows[0]  = '{KIND_NEXT, 4'd0, 31'd0, 1'b1, '{KIND_NEXT, 1'b1, 4'd0, 32'sd0, 1'b1}};
    dir_rows[1]  = '{KIND_REM, 4'd0, 31'd0, 1'b1, '{KIND_REM, 1'b1, 4'd0, 32'sd0, 1'b1}};
    dir_rows[2]  = '{KIND_CANCEL, 4'd15, 31'd0, 1'b1,
                     '{KIND_CANCEL, 1'b1, 4'd15, 32'sd0, 1'b1}};
    dir_rows[3]  = '{KIND_SET, 4'd0, 31'd0, 1'b1, '{KIND_SET, 1'b0, 4'd0, 32'sd0, 1'b1}};
    dir_rows[4]  = '{KIND_SET, 4'd15, {MsW{1'b1}}, 1'b1,
                     '{KIND_SET, 1'b0, 4'd15, 32'sd0, 1'b1}};
    dir_rows[5]  = '{KIND_REM, 4'd15, 31'd0, 1'b1,
                     '{KIND_REM, 1'b0, 4'd15, 32'sh7fffffff, 1'b1}};
    dir_rows[6]  = '{KIND_NEXT, 4'd0, 31'd0, 1'b1, '{KIND_NEXT, 1'b0, 4'd0, 32'sd0, 1'b1}};
    dir_rows[7]  = '{KIND_TICK, 4'd0, 31'd0, 1'b1, '{KIND_TICK, 1'b0, 4'd0, 32'sd0, 1'b1}};
    dir_rows[8]  = '{KIND_SET, 4'd5, 31'd2, 1'b0, '0};
    dir_rows[9]  = '{KIND_SET, 4'd6, 31'd2, 1'b0, '0};
    // re-arm with an equal deadline moves it behind the tie
    dir_rows[10] = '{KIND_SET, 4'd5, 31'd2, 1'b0, '0};
    dir_rows[11] = '{KIND_SET, 4'd10, 31'h2aaaaaaa, 1'b0, '0};
    dir_rows[12] = '{KIND_SET, 4'd11, 31'h55555555, 1'b0, '0};
    dir_rows[13] = '{3'd5, 4'd3, 31'd1, 1'b0, '0};
    dir_rows[14] = '{3'd6, 4'd9, 31'd1, 1'b0, '0};
    dir_rows[15] = '{3'd7, 4'd15, {MsW{1'b1}}, 1'b0, '0};
    dir_rows[16] = '{KIND_TICK, 4'd15, {MsW{1'b1}}, 1'b0, '0};
    dir_rows[17] = '{KIND_TICK, 4'd0, 31'd0, 1'b0, '0};
    dir_rows[18] = '{KIND_REM, 4'd6, 31'd0, 1'b0, '0};
    dir_rows[19] = '{KIND_CANCEL, 4'd10, 31'd0, 1'b0, '0};
    dir_rows[20] = '{KIND_CANCEL, 4'd10, 31'd0, 1'b0, '0};
    dir_rows[21] = '{KIND_NEXT, 4'd0, 31'd0, 1'b0, '0};
    dir_rows[22] = '{KIND_CANCEL, 4'd15, 31'd0, 1'b0, '0};
    dir_rows[23] = '{KIND_NEXT, 4'd0, 31'd0, 1'b0, '0};

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].id, dir_rows[i].msecs,
                dir_rows[i].typed, dir_rows[i].res);
    random_items(60);

    // long receiver hold while items keep coming
    sender_idle = 0;
    want_hold = 1'b1;
    random_items(12);
    // sender waits for every result before going on
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);

    sender_idle = 85;
    receiver_idle = 16;
    random_items(50);
    sender_idle = 0;
    receiver_idle = 0;
    random_items(50);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d input items (ticks, sets, cancels, queries, bad kinds, full bursts)",
             sent_items);
    $display("checked %0d result beats under three stall mixes and a long receiver hold",
             seen_results);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("sorted_timeout_queue_core_tb: clean");
    end else begin
      $display("sorted_timeout_queue_core_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sorted_timeout_queue_core.f
+incdir+design
design/stq_pkg.sv
design/sorted_timeout_queue_core.sv
design/stq_checker.sv
test/sorted_timeout_queue_core_tb.sv
